### sv/mfq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared types and codes of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfq_pkg;

    // command codes
    localparam logic [2:0] CMD_ADMIT   = 3'd0;
    localparam logic [2:0] CMD_WAKE    = 3'd1;
    localparam logic [2:0] CMD_REMOVE  = 3'd2;
    localparam logic [2:0] CMD_SCHED   = 3'd3;
    localparam logic [2:0] CMD_REQUEUE = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOCHANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_QUANTUM0 = 3'd0;
    localparam logic [2:0] CFG_QUANTUM4 = 3'd4;
    localparam logic [2:0] CFG_AGING    = 3'd5;

    localparam int NUM_QUANTA = 5;
    localparam logic [7:0]  QUANTUM_RESET [NUM_QUANTA] = '{8'd2, 8'd4, 8'd8, 8'd16, 8'd32};
    localparam logic [15:0] AGING_RESET = 16'd25;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  proc_id;
        logic [31:0] now;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic       granted_valid;
        logic [5:0] granted_id;
        logic [2:0] granted_level;
        logic       demoted;
    } t_out;

    // per-queue operation: shift drops the head, load writes one cell
    typedef struct packed {
        logic shift;
        logic load;
    } t_qop;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_REC,
        S_REMOVE,
        S_ADMIT,
        S_AGE_RD,
        S_AGE_CHK,
        S_GRANT,
        S_GRANT_WR,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### sv/mfq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfq_cell
// One queue position: holds a process id, takes its right neighbor on shift.
// ----------------------------------------------------------------------------
module mfq_cell import mfq_pkg::*; #(
    parameter int IDW = 6
) (
    input  wire logic           i_clk,
    input  wire logic           i_shift,
    input  wire logic           i_load,
    input  wire logic [IDW-1:0] i_val,
    input  wire logic [IDW-1:0] i_right,
    output logic      [IDW-1:0] o_data
);

    logic [IDW-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_val;
        end else if (i_shift) begin
            r_data <= i_right;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

### sv/mfq_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfq_queue
// One priority level: a row of cells, head at cell 0.
// ----------------------------------------------------------------------------
module mfq_queue import mfq_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int IDW   = 6,
    parameter int LENW  = 7
) (
    input  wire logic            i_clk,
    input  wire t_qop            i_op,
    input  wire logic [LENW-1:0] i_pos,
    input  wire logic [IDW-1:0]  i_val,
    output logic      [IDW-1:0]  o_head
);

    logic [IDW-1:0] w_data [DEPTH+1];

    assign w_data[DEPTH] = '0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        mfq_cell #(.IDW(IDW)) u_cell (
            .i_clk   (i_clk),
            .i_shift (i_op.shift),
            .i_load  (i_op.load && (i_pos == LENW'(gi))),
            .i_val   (i_val),
            .i_right (w_data[gi+1]),
            .o_data  (w_data[gi])
        );
    end

    assign o_head = w_data[0];

endmodule
`default_nettype wire

### sv/multilevel_feedback_queue_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Multilevel feedback queue scheduler with aging, one command per beat.
// ----------------------------------------------------------------------------
// Each level is a row of cells that shifts toward its head; an item is
// visited by moving the head either back to the tail or to another row, so
// no search runs over the cells. One command is in flight at a time. Admit
// and remove of a queued process visit every entry of its level. Schedule
// visits every entry queued at levels 1 and up (one stamp memory read, then
// the age compare) before it grants. The result waits in an output register,
// so the next beat is taken while it is still stalled. Records reset through
// valid bits: no clearing pass.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler import mfq_pkg::*; #(
    parameter int PROCESSES  = 64,
    parameter int LEVELS     = 5,
    parameter int COUNT_BITS = 8,
    parameter int TIME_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command beats
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    // result beats
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    localparam int IDW  = $clog2(PROCESSES);
    localparam int LENW = $clog2(PROCESSES + 1);
    localparam int LW   = $clog2(LEVELS);
    localparam int ALW  = $clog2(LEVELS + 1);
    localparam int CW   = LEVELS * COUNT_BITS;
    localparam int RW   = LW + CW;          // record row: level, grant counts
    localparam int QCW  = 17;               // common width for quantum compare

    // configuration
    logic [7:0]  r_quantum [NUM_QUANTA];
    logic [15:0] r_aging;

    // control
    t_state r_state, n_state;
    t_in    r_in;
    t_out   r_res;
    logic   r_out_valid;
    t_out   r_out;
    logic [LENW-1:0] r_len [LEVELS];
    logic [LENW-1:0] r_k;                   // entries left to visit
    logic [ALW-1:0]  r_alv;                 // level the aging walk is on
    logic [LW-1:0]   r_lv;
    logic [IDW-1:0]  r_gid;
    logic [PROCESSES-1:0] r_queued;
    logic [PROCESSES-1:0] r_mark;
    logic [PROCESSES-1:0] r_rec_vld;

    // record and stamp memories
    logic [RW-1:0]        rec_mem   [PROCESSES];
    logic [TIME_BITS-1:0] stamp_mem [PROCESSES];
    logic [RW-1:0]        r_rd_row;
    logic                 r_rd_vld;
    logic [TIME_BITS-1:0] r_rd_stamp;

    // queue rows
    t_qop            w_qop  [LEVELS];
    logic [LENW-1:0] w_qpos [LEVELS];
    logic [IDW-1:0]  w_qval [LEVELS];
    logic [IDW-1:0]  w_head [LEVELS];

    logic [IDW-1:0]       w_id;
    logic                 w_bad;
    logic [TIME_BITS-1:0] w_now;
    logic [LW-1:0]        w_alv;
    logic [ALW-1:0]       w_nalv;
    logic                 w_aged;
    logic [RW-1:0]        w_row;
    logic [LW-1:0]        w_rd_lvl;
    logic [LW-1:0]        w_sel_lv;
    logic [COUNT_BITS-1:0] w_cnt, w_cnt_inc;
    logic [7:0]           w_quant;
    logic                 w_reach, w_reach_inc;
    logic                 w_mk;
    logic                 w_can_demote;
    logic [LW-1:0]        w_new_lv;
    logic [CW-1:0]        w_cnt_row;
    logic                 w_gfound;
    logic [LW-1:0]        w_glv;

    // memory port controls
    logic                 w_rd_en;
    logic [IDW-1:0]       w_rd_addr;
    logic                 w_rec_we;
    logic [IDW-1:0]       w_wr_addr;
    logic [RW-1:0]        w_rec_wd;
    logic                 w_stamp_we;

    assign w_id   = IDW'(r_in.proc_id);
    assign w_bad  = (r_in.cmd > CMD_REQUEUE) || (32'(r_in.proc_id) >= PROCESSES);
    assign w_now  = TIME_BITS'(r_in.now);
    assign w_alv  = r_alv[LW-1:0];
    assign w_nalv = r_alv + ALW'(1);

    // record read data, an unwritten record reads as all zero
    assign w_row    = r_rd_vld ? r_rd_row : '0;
    assign w_rd_lvl = w_row[RW-1 -: LW];

    // quantum and count of the level in question
    assign w_sel_lv  = (r_state == S_GRANT_WR) ? r_lv : w_rd_lvl;
    assign w_cnt     = w_row[32'(w_sel_lv) * COUNT_BITS +: COUNT_BITS];
    assign w_cnt_inc = (w_cnt == '1) ? w_cnt : w_cnt + COUNT_BITS'(1);
    assign w_quant   = (32'(w_sel_lv) >= NUM_QUANTA) ? r_quantum[NUM_QUANTA-1]
                                                     : r_quantum[w_sel_lv];
    assign w_reach     = QCW'(w_cnt) >= QCW'(w_quant);
    assign w_reach_inc = QCW'(w_cnt_inc) >= QCW'(w_quant);

    // requeue: a process marked or at its quantum drops one level unless already at the bottom
    assign w_mk         = r_mark[w_id] || w_reach;
    assign w_can_demote = 32'(w_rd_lvl) < LEVELS - 1;
    assign w_new_lv     = (w_mk && w_can_demote) ? w_rd_lvl + LW'(1) : w_rd_lvl;

    always_comb begin
        w_cnt_row = w_row[CW-1:0];
        w_cnt_row[32'(w_sel_lv) * COUNT_BITS +: COUNT_BITS] = w_cnt_inc;
    end

    // age compare, difference wraps modulo the stamp width
    assign w_aged = (w_now - r_rd_stamp) > TIME_BITS'(r_aging);

    // highest nonempty level
    always_comb begin
        w_gfound = 1'b0;
        w_glv    = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_len[l] != '0) begin
                w_gfound = 1'b1;
                w_glv    = LW'(l);
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer, next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_START;
            end
            S_START: begin
                if (r_in.cmd == CMD_SCHED) begin
                    n_state = S_AGE_RD;
                end else if (w_bad) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_REC;
                end
            end
            S_REC: begin
                if (r_in.cmd == CMD_ADMIT) begin
                    n_state = r_queued[w_id] ? S_REMOVE : S_ADMIT;
                end else if (r_in.cmd == CMD_REMOVE && r_queued[w_id]) begin
                    n_state = S_REMOVE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REMOVE: begin
                if (r_k == '0) n_state = (r_in.cmd == CMD_ADMIT) ? S_ADMIT : S_DONE;
            end
            S_ADMIT:    n_state = S_DONE;
            S_AGE_RD: begin
                if (32'(r_alv) >= LEVELS) begin
                    n_state = S_GRANT;
                end else if (r_k != '0) begin
                    n_state = S_AGE_CHK;
                end
            end
            S_AGE_CHK:  n_state = S_AGE_RD;
            S_GRANT:    n_state = w_gfound ? S_GRANT_WR : S_DONE;
            S_GRANT_WR: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer, outputs to queue rows and memories
    // ------------------------------------------------------------------
    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            w_qop[l]  = '0;
            w_qpos[l] = '0;
            w_qval[l] = '0;
        end
        w_rd_en    = 1'b0;
        w_rd_addr  = '0;
        w_rec_we   = 1'b0;
        w_wr_addr  = w_id;
        w_rec_wd   = '0;
        w_stamp_we = 1'b0;
        unique case (r_state)
            S_START: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_id;
            end
            S_REC: begin
                if (!r_queued[w_id]) begin
                    // wake keeps its level, requeue may drop one
                    if (r_in.cmd == CMD_WAKE) begin
                        w_qop[w_rd_lvl].load = 1'b1;
                        w_qpos[w_rd_lvl]     = r_len[w_rd_lvl];
                        w_qval[w_rd_lvl]     = w_id;
                        w_stamp_we           = 1'b1;
                    end else if (r_in.cmd == CMD_REQUEUE) begin
                        w_qop[w_new_lv].load = 1'b1;
                        w_qpos[w_new_lv]     = r_len[w_new_lv];
                        w_qval[w_new_lv]     = w_id;
                        w_stamp_we           = 1'b1;
                        w_rec_we             = 1'b1;
                        w_rec_wd             = {w_new_lv, w_row[CW-1:0]};
                    end
                end
            end
            S_REMOVE: begin
                // head leaves; anything but the target goes back to the tail
                if (r_k != '0) begin
                    w_qop[r_lv].shift = 1'b1;
                    if (w_head[r_lv] != w_id) begin
                        w_qop[r_lv].load = 1'b1;
                        w_qpos[r_lv]     = r_len[r_lv] - LENW'(1);
                        w_qval[r_lv]     = w_head[r_lv];
                    end
                end
            end
            S_ADMIT: begin
                w_qop[0].load = 1'b1;
                w_qpos[0]     = r_len[0];
                w_qval[0]     = w_id;
                w_stamp_we    = 1'b1;
                w_rec_we      = 1'b1;
                w_rec_wd      = '0;
            end
            S_AGE_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_head[w_alv];
            end
            S_AGE_CHK: begin
                w_qop[w_alv].shift = 1'b1;
                if (w_aged) begin
                    // promote to the tail of the level above
                    w_qop[w_alv - LW'(1)].load = 1'b1;
                    w_qpos[w_alv - LW'(1)]     = r_len[w_alv - LW'(1)];
                    w_qval[w_alv - LW'(1)]     = w_head[w_alv];
                    w_wr_addr                  = w_head[w_alv];
                    w_stamp_we                 = 1'b1;
                    w_rec_we                   = 1'b1;
                    w_rec_wd                   = {w_alv - LW'(1), w_row[CW-1:0]};
                end else begin
                    w_qop[w_alv].load = 1'b1;
                    w_qpos[w_alv]     = r_len[w_alv] - LENW'(1);
                    w_qval[w_alv]     = w_head[w_alv];
                end
            end
            S_GRANT: begin
                if (w_gfound) begin
                    w_qop[w_glv].shift = 1'b1;
                    w_rd_en            = 1'b1;
                    w_rd_addr          = w_head[w_glv];
                end
            end
            S_GRANT_WR: begin
                w_wr_addr = r_gid;
                w_rec_we  = 1'b1;
                w_rec_wd  = {w_rd_lvl, w_cnt_row};
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // queue rows
    // ------------------------------------------------------------------
    for (genvar gl = 0; gl < LEVELS; gl++) begin : g_level
        mfq_queue #(.DEPTH(PROCESSES), .IDW(IDW), .LENW(LENW)) u_queue (
            .i_clk  (i_clk),
            .i_op   (w_qop[gl]),
            .i_pos  (w_qpos[gl]),
            .i_val  (w_qval[gl]),
            .o_head (w_head[gl])
        );
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_rec_we) rec_mem[w_wr_addr] <= w_rec_wd;
        if (w_stamp_we) stamp_mem[w_wr_addr] <= w_now;
        if (w_rd_en) begin
            r_rd_row   <= rec_mem[w_rd_addr];
            r_rd_stamp <= stamp_mem[w_rd_addr];
            r_rd_vld   <= r_rec_vld[w_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_queued    <= '0;
            r_mark      <= '0;
            r_rec_vld   <= '0;
            r_aging     <= AGING_RESET;
            for (int q = 0; q < NUM_QUANTA; q++) r_quantum[q] <= QUANTUM_RESET[q];
            for (int l = 0; l < LEVELS; l++) r_len[l] <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_AGING) begin
                    r_aging <= i_cfg_data;
                end else if (i_cfg_idx <= CFG_QUANTUM4) begin
                    r_quantum[i_cfg_idx - CFG_QUANTUM0] <= i_cfg_data[7:0];
                end
            end

            // lengths follow the row operations: pop shrinks, append grows
            for (int l = 0; l < LEVELS; l++) begin
                if (w_qop[l].load && !w_qop[l].shift) begin
                    r_len[l] <= r_len[l] + LENW'(1);
                end else if (w_qop[l].shift && !w_qop[l].load) begin
                    r_len[l] <= r_len[l] - LENW'(1);
                end
            end

            if (w_rec_we) r_rec_vld[w_wr_addr] <= 1'b1;

            unique case (r_state)
                S_REC: begin
                    if (r_in.cmd == CMD_REMOVE && r_queued[w_id]) begin
                        r_queued[w_id] <= 1'b0;
                    end else if ((r_in.cmd == CMD_WAKE || r_in.cmd == CMD_REQUEUE)
                                 && !r_queued[w_id]) begin
                        r_queued[w_id] <= 1'b1;
                        if (r_in.cmd == CMD_REQUEUE) r_mark[w_id] <= 1'b0;
                    end
                end
                S_ADMIT: begin
                    r_queued[w_id] <= 1'b1;
                    r_mark[w_id]   <= 1'b0;
                end
                S_GRANT: begin
                    if (w_gfound) r_queued[w_head[w_glv]] <= 1'b0;
                end
                S_GRANT_WR: begin
                    if (w_reach_inc) r_mark[r_gid] <= 1'b1;
                end
                default: begin
                end
            endcase

            // result register toward the consumer
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) r_in <= i_in_data;
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) r_out <= r_res;

        unique case (r_state)
            S_START: begin
                r_res <= '{status: ST_NOCHANGE, granted_valid: 1'b0, granted_id: '0,
                           granted_level: '0, demoted: 1'b0};
                r_alv <= ALW'(1);
                r_k   <= r_len[1];
            end
            S_REC: begin
                r_lv <= w_rd_lvl;
                r_k  <= r_len[w_rd_lvl];
                unique case (r_in.cmd)
                    CMD_ADMIT: r_res.status <= ST_DONE;
                    CMD_REMOVE: begin
                        if (r_queued[w_id]) r_res.status <= ST_DONE;
                    end
                    CMD_WAKE: begin
                        if (!r_queued[w_id]) r_res.status <= ST_DONE;
                    end
                    CMD_REQUEUE: begin
                        if (!r_queued[w_id]) begin
                            r_res.status  <= ST_DONE;
                            r_res.demoted <= w_mk && w_can_demote;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_REMOVE, S_AGE_CHK: begin
                if (r_k != '0) r_k <= r_k - LENW'(1);
            end
            S_AGE_RD: begin
                // level done, move on to the next one down
                if (32'(r_alv) < LEVELS && r_k == '0) begin
                    r_alv <= w_nalv;
                    r_k   <= (32'(w_nalv) < LEVELS) ? r_len[w_nalv[LW-1:0]] : '0;
                end
            end
            S_GRANT: begin
                r_res.status <= ST_EMPTY;
                r_gid        <= w_head[w_glv];
                r_lv         <= w_glv;
            end
            S_GRANT_WR: begin
                r_res.status        <= ST_DONE;
                r_res.granted_valid <= 1'b1;
                r_res.granted_id    <= 6'(r_gid);
                r_res.granted_level <= 3'(r_lv);
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // one command at a time: an accepted beat blocks the input next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a command is in flight");

    // a grant always reports done
    a_grant_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.granted_valid) |-> (r_res.status == ST_DONE))
        else $error("grant with wrong status");

    // level 0 never holds more entries than there are processes
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len[0]) <= PROCESSES)
        else $error("level 0 length out of range");
`endif

endmodule
`default_nettype wire
